// File: sv/assert_macros.svh
// Assertion macros used by the top level of the content field extractor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed: expr");

// The antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: ante implies cons");

// The antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: ante then cons");

`endif

// File: sv/jcfe_pkg.sv
// Types, constants and the key matcher function of the content field extractor.
package jcfe_pkg;

    localparam int BUFFER_BYTES = 1024;
    localparam int LEN_W        = ($clog2(BUFFER_BYTES) > 10) ? $clog2(BUFFER_BYTES) : 10;
    localparam int INDEX_W      = 10;
    localparam int KEY_LEN      = 11;
    localparam int POS_W        = $clog2(KEY_LEN);

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(BUFFER_BYTES - 1);

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO      = 8'h00;

    localparam logic [7:0] KEY_TEXT [KEY_LEN] = '{
        8'h22, 8'h63, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h22, 8'h3A, 8'h22
    };

    // Longest proper border of the first q+1 key bytes.
    localparam logic [POS_W-1:0] KEY_FALLBACK [KEY_LEN] = '{
        POS_W'(0), POS_W'(0), POS_W'(0), POS_W'(0), POS_W'(0), POS_W'(0),
        POS_W'(0), POS_W'(0), POS_W'(1), POS_W'(0), POS_W'(1)
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       chunk_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0]         content_byte;
        logic [INDEX_W-1:0] buffer_index;
    } t_out_item;

    typedef struct packed {
        logic [POS_W-1:0] key_pos;
        logic             in_content;
        logic             escape;
        logic             stopped;
        logic [LEN_W-1:0] length;
    } t_parse_state;

    // One matcher step. Every border of this key is at most one byte long, so the
    // fallback chain is never deeper than the current position, its border and zero.
    function automatic logic [POS_W-1:0] next_key_pos(input logic [POS_W-1:0] pos,
                                                       input logic [7:0] b);
        logic [POS_W-1:0] q;
        logic [POS_W-1:0] f;
        q = (pos >= POS_W'(KEY_LEN)) ? '0 : pos;
        f = (q != '0) ? KEY_FALLBACK[q - 1'b1] : '0;
        if (KEY_TEXT[q] == b) begin
            return q + 1'b1;
        end else if (q != '0 && KEY_TEXT[f] == b) begin
            return f + 1'b1;
        end else if (KEY_TEXT[0] == b) begin
            return POS_W'(1);
        end
        return '0;
    endfunction

endpackage

// File: sv/jcfe_parser.sv
// Per-byte parser state: key matcher, content and escape tracking, response length.
module jcfe_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  jcfe_pkg::t_in_item    i_item,
    output logic                  o_emit,
    output jcfe_pkg::t_out_item   o_item,
    output jcfe_pkg::t_parse_state o_state
);
    import jcfe_pkg::*;

    t_parse_state r_state;
    t_parse_state n_state;
    logic [POS_W-1:0] key_next;

    assign key_next = next_key_pos(r_state.key_pos, i_item.data_byte);

    always_comb begin
        n_state = r_state;
        o_emit  = 1'b0;
        o_item.content_byte = i_item.data_byte;
        o_item.buffer_index = r_state.length[INDEX_W-1:0];
        if (!r_state.stopped) begin
            if (i_item.data_byte == CH_ZERO) begin
                n_state.stopped    = 1'b1;
                n_state.in_content = 1'b0;
                n_state.escape     = 1'b0;
            end else if (r_state.in_content) begin
                o_emit = 1'b1;
                if (r_state.escape) begin
                    n_state.escape = 1'b0;
                end else if (i_item.data_byte == CH_BACKSLASH) begin
                    n_state.escape = 1'b1;
                end else if (i_item.data_byte == CH_QUOTE) begin
                    o_emit = 1'b0;
                    n_state.in_content = 1'b0;
                    n_state.key_pos    = POS_W'(1);
                end
                if (r_state.length >= LEN_MAX) begin
                    o_emit = 1'b0;
                end
                if (o_emit) begin
                    n_state.length = r_state.length + 1'b1;
                end
            end else if (key_next == POS_W'(KEY_LEN)) begin
                n_state.key_pos    = '0;
                n_state.in_content = 1'b1;
                n_state.escape     = 1'b0;
            end else begin
                n_state.key_pos = key_next;
            end
        end
        if (i_item.chunk_end) begin
            n_state.key_pos    = '0;
            n_state.in_content = 1'b0;
            n_state.escape     = 1'b0;
            n_state.stopped    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_fire) begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

// File: sv/json_content_field_extractor_core.sv
// Top level of the content field extractor: input register, parser and result register.
// The block scans a chunked byte stream for the key "content":" and passes on every byte
// that follows, up to the unescaped closing quote, with its position in the response; a
// backslash and the byte after it are passed on raw. It takes one byte per clock cycle
// while the output is not stalled, and a result is presented at the edge where the
// parser moves its byte from the input register into the result register. A stalled
// result holds the input register and stalls the input. A zero byte silences the rest
// of its chunk, all matching state clears at each chunk end, and once the response
// holds BUFFER_BYTES - 1 bytes further content bytes are dropped.
`include "assert_macros.svh"

module json_content_field_extractor_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  jcfe_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output jcfe_pkg::t_out_item o_out_item
);
    import jcfe_pkg::*;

    logic         r_in_valid;
    t_in_item     r_in_item;
    logic         r_out_valid;
    t_out_item    r_out_item;
    logic         out_free;
    logic         fire;
    logic         emit;
    t_out_item    result;
    t_parse_state state;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    jcfe_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in_item),
        .o_emit  (emit),
        .o_item  (result),
        .o_state (state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= fire && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && fire && emit) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `ASSERT_ALWAYS(a_key_pos_range, i_clk, i_rst_n, state.key_pos < POS_W'(KEY_LEN))
    `ASSERT_IMPLY(a_stop_closes_content, i_clk, i_rst_n, state.stopped, !state.in_content)
    `ASSERT_IMPLY(a_escape_in_content, i_clk, i_rst_n, state.escape, state.in_content)
    `ASSERT_NEXT(a_emit_reaches_output, i_clk, i_rst_n, fire && emit, r_out_valid)

endmodule
